// File: src/ers_pkg.sv
package ers_pkg;

    // Sizing
    localparam int MAX_REPLICAS = 16;
    localparam int IDX_W        = $clog2(MAX_REPLICAS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int CFG_W        = 5;
    localparam int ELITE_MAX    = (MAX_REPLICAS + 3) / 4;
    localparam int ELITE_W      = $clog2(ELITE_MAX + 1);
    localparam int ELITE_IDX_W  = (ELITE_MAX > 1) ? $clog2(ELITE_MAX) : 1;
    localparam int COST_W       = 32;
    localparam int SUM_W        = COST_W + 1;
    localparam int KEY_W        = SUM_W + 1;
    localparam int ENERGY_W     = 32;
    localparam int RANK_W       = KEY_W + ENERGY_W;
    localparam int FIFO_DEPTH   = 2;

    localparam logic [CFG_W-1:0] CFG_COUNT_RESET = CFG_W'(8);

    // Input transaction
    typedef struct packed {
        logic                       is_valid_solution;
        logic [COST_W-1:0]          overlap_cost;
        logic [COST_W-1:0]          boundary_cost;
        logic signed [ENERGY_W-1:0] total_energy;
    } t_item;

    // Result transaction
    typedef struct packed {
        logic [IDX_W-1:0] victim_index;
        logic [IDX_W-1:0] source_index;
        logic             final_pair;
    } t_result;

    // Classified record passed from front to back.
    // rank_key compares as unsigned: {infeasible, penalty sum, energy with sign flipped}
    typedef struct packed {
        logic [RANK_W-1:0] rank_key;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_rec;

    // Effective replica count: zero acts as one, clipped to the table size
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] raw);
        logic [CFG_W+CNT_W-1:0] ext;
        logic [CNT_W-1:0]       res;
        ext = (CFG_W+CNT_W)'(raw);
        if (ext == '0) begin
            res = CNT_W'(1);
        end else if (ext > (CFG_W+CNT_W)'(MAX_REPLICAS)) begin
            res = CNT_W'(MAX_REPLICAS);
        end else begin
            res = ext[CNT_W-1:0];
        end
        return res;
    endfunction

    // Elite size: ceil(count / 4)
    function automatic logic [ELITE_W-1:0] elite_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] sum;
        logic [CNT_W:0] quo;
        sum = {1'b0, cnt} + (CNT_W+1)'(3);
        quo = sum >> 2;
        return quo[ELITE_W-1:0];
    endfunction

endpackage

// File: src/ers_front.sv
module ers_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  ers_pkg::t_item             i_item,
    input  logic [ers_pkg::CNT_W-1:0]  i_count,
    output logic                       o_push,
    output ers_pkg::t_rec              o_rec
);
    import ers_pkg::*;

    logic [IDX_W-1:0] r_load_count;
    logic [IDX_W-1:0] n_load_count;
    logic [SUM_W-1:0] pen_sum;
    logic [CNT_W-1:0] slot_next;
    logic             close_round;

    // Penalty sum is exact at 33 bits
    assign pen_sum = SUM_W'(i_item.overlap_cost) + SUM_W'(i_item.boundary_cost);

    // Round closes when this slot fills the configured count
    assign slot_next   = CNT_W'(r_load_count) + CNT_W'(1);
    assign close_round = (slot_next >= i_count);

    always_comb begin
        n_load_count = r_load_count;
        if (i_accept) begin
            n_load_count = close_round ? '0 : slot_next[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else begin
            r_load_count <= n_load_count;
        end
    end

    // Classify the record into one unsigned rank key
    assign o_push        = i_accept;
    assign o_rec.rank_key = {~i_item.is_valid_solution, pen_sum,
                             ~i_item.total_energy[ENERGY_W-1],
                             i_item.total_energy[ENERGY_W-2:0]};
    assign o_rec.idx     = r_load_count;
    assign o_rec.last    = close_round;

endmodule

// File: src/ers_fifo.sv
module ers_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ers_pkg::t_rec  i_rec,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ers_pkg::t_rec  o_rec
);
    import ers_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

    t_rec             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [OCC_W-1:0] r_occ;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_occ == OCC_W'(FIFO_DEPTH));
    assign o_empty = (r_occ == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if (do_pop && !do_push) begin
                r_occ <= r_occ - OCC_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// File: src/ers_back.sv
module ers_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rec_valid,
    input  ers_pkg::t_rec              i_rec,
    input  logic [ers_pkg::CNT_W-1:0]  i_count,
    output logic                       o_pop,
    output logic                       o_strobe,
    output ers_pkg::t_result           o_result
);
    import ers_pkg::*;

    localparam logic [1:0] ST_SORT = 2'd0;
    localparam logic [1:0] ST_PACK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_wptr;
    logic [CNT_W-1:0]   r_emit;
    logic               r_strobe;
    t_result            r_result;

    // Sorted row of cells
    logic [RANK_W-1:0]  r_srt_key [MAX_REPLICAS];
    logic [IDX_W-1:0]   r_srt_idx [MAX_REPLICAS];
    // Elite ring and victim line in rank order
    logic [IDX_W-1:0]   r_elite   [ELITE_MAX];
    logic [IDX_W-1:0]   r_victim  [MAX_REPLICAS];

    logic [ELITE_W-1:0] elite_k;
    logic [CNT_W-1:0]   victim_n;
    logic [MAX_REPLICAS-1:0] ins;
    logic               do_insert;
    logic               do_pack;
    logic               pack_keep;
    logic               do_emit;

    assign elite_k  = elite_count(i_count);
    assign victim_n = i_count - CNT_W'(elite_k);

    // Per-cell insert position: first cell the new record beats, or the fill point
    always_comb begin
        for (int j = 0; j < MAX_REPLICAS; j++) begin
            ins[j] = ((i_rec.rank_key < r_srt_key[j]) && (CNT_W'(j) < r_fill))
                     || (CNT_W'(j) == r_fill);
        end
    end

    assign do_insert = (r_state == ST_SORT) && i_rec_valid;
    assign o_pop     = do_insert;
    assign do_pack   = (r_state == ST_PACK) && (r_fill != '0);
    assign pack_keep = (CNT_W'(r_srt_idx[0]) < i_count);
    assign do_emit   = (r_state == ST_EMIT) && (r_emit != victim_n);

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SORT: begin
                if (do_insert && i_rec.last) begin
                    n_state = ST_PACK;
                end
            end
            ST_PACK: begin
                if (r_fill == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_emit == victim_n) begin
                    n_state = ST_SORT;
                end
            end
            default: n_state = ST_SORT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SORT;
            r_fill   <= '0;
            r_wptr   <= '0;
            r_emit   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= do_emit;
            if (do_insert) begin
                r_fill <= r_fill + CNT_W'(1);
                r_wptr <= '0;
            end else if (do_pack) begin
                r_fill <= r_fill - CNT_W'(1);
                if (pack_keep) begin
                    r_wptr <= r_wptr + CNT_W'(1);
                end
            end
            if (r_state == ST_PACK) begin
                r_emit <= '0;
            end else if (do_emit) begin
                r_emit <= r_emit + CNT_W'(1);
            end
        end
    end

    // Sorted row: insertion shifts right, packing shifts left
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_REPLICAS; j++) begin
            if (do_insert && ins[j]) begin
                if (j > 0 && ins[(j > 0) ? j - 1 : 0]) begin
                    r_srt_key[j] <= r_srt_key[(j > 0) ? j - 1 : 0];
                    r_srt_idx[j] <= r_srt_idx[(j > 0) ? j - 1 : 0];
                end else begin
                    r_srt_key[j] <= i_rec.rank_key;
                    r_srt_idx[j] <= i_rec.idx;
                end
            end else if (do_pack && j < MAX_REPLICAS - 1) begin
                r_srt_key[j] <= r_srt_key[(j < MAX_REPLICAS - 1) ? j + 1 : j];
                r_srt_idx[j] <= r_srt_idx[(j < MAX_REPLICAS - 1) ? j + 1 : j];
            end
        end
    end

    // Elite ring: filled while packing, rotated over the elite size while emitting
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ELITE_MAX; j++) begin
            if (do_pack && pack_keep && r_wptr == CNT_W'(j)) begin
                r_elite[j] <= r_srt_idx[0];
            end else if (do_emit) begin
                if (ELITE_W'(j + 1) == elite_k) begin
                    r_elite[j] <= r_elite[0];
                end else begin
                    r_elite[j] <= r_elite[(j + 1) % ELITE_MAX];
                end
            end
        end
    end

    // Victim line: filled past the elite while packing, shifted while emitting
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_REPLICAS; j++) begin
            if (do_pack && pack_keep && r_wptr == CNT_W'(j) + CNT_W'(elite_k)) begin
                r_victim[j] <= r_srt_idx[0];
            end else if (do_emit && j < MAX_REPLICAS - 1) begin
                r_victim[j] <= r_victim[(j < MAX_REPLICAS - 1) ? j + 1 : j];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_result.victim_index <= r_victim[0];
            r_result.source_index <= r_elite[0];
            r_result.final_pair   <= (r_emit + CNT_W'(1) == victim_n);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: src/elite_rank_resample_select_core.sv
// Channel   | Signals                       | Handshake
// ----------+-------------------------------+-------------------------------------
// score in  | i_item                        | taken when start high and busy low
// config    | i_cfg_we, i_cfg_data          | written when i_cfg_we high
// pairs out | o_result                      | valid for one cycle with o_strobe
//
// Each record is classified combinationally and queued, then inserted into the sorted row
// while the back end is in its sort state. Closing a round packs the rank order, then emits the
// victim pairs, one pair per cycle on o_strobe. busy rises while the two-entry queue is
// full, as happens when records of the next round arrive during packing and emission.
// The receiver cannot stall the pairs.
// Reset (synchronous, active low) empties the queue, restarts loading at replica 0
// and sets the replica count to 8.
module elite_rank_resample_select_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ers_pkg::t_item               i_item,
    input  logic                         i_cfg_we,
    input  logic [ers_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_strobe,
    output ers_pkg::t_result             o_result
);
    import ers_pkg::*;

    logic [CFG_W-1:0] r_cfg_count;
    logic [CNT_W-1:0] count;
    logic             accept;
    logic             push;
    t_rec             front_rec;
    t_rec             queue_rec;
    logic             queue_full;
    logic             queue_empty;
    logic             pop;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= CFG_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_cfg_count <= i_cfg_data;
        end
    end

    assign count  = eff_count(r_cfg_count);
    assign busy   = queue_full;
    assign accept = start && !queue_full;

    ers_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_count  (count),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    ers_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_rec   (queue_rec)
    );

    ers_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!queue_empty),
        .i_rec       (queue_rec),
        .i_count     (count),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import ers_pkg::*;

    localparam int TARGET_ITEMS   = 310;
    localparam int SETTLE_CYCLES  = 48;    // queue, insert, pack and emit of a full round, with margin
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum logic [1:0] {ROW_CFG, ROW_RECORD, ROW_TYPED} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [CFG_W-1:0] cfg;
        t_item            rec;
        t_result          want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_item            i_item = '0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             o_strobe;
    t_result          o_result;

    // Shadow state of the ranking block
    logic [CFG_W-1:0]    replica_cfg = CFG_W'(8);
    logic [KEY_W-1:0]    penalty_key [MAX_REPLICAS];
    logic [ENERGY_W-1:0] energy_val [MAX_REPLICAS];
    int                  load_slot = 0;

    t_result pending_pairs[$];   // victim pairs still owed by the block
    t_result round_pairs[$];     // pairs produced by the record just absorbed
    t_row    plan[$];
    t_item   last_rec = '0;

    int errors = 0;
    int items_sent = 0;
    int rounds_closed = 0;
    int pairs_seen = 0;
    int cfg_writes = 0;
    int quiet = 0;

    elite_rank_resample_select_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count register as the block sees it: zero means one, clipped at the table size
    function automatic int live_count(input logic [CFG_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end else if (raw > CFG_W'(MAX_REPLICAS)) begin
            return MAX_REPLICAS;
        end
        return int'(raw);
    endfunction

    // Replica a ranks strictly ahead of replica b
    function automatic bit ranks_first(input int a, input int b);
        if (penalty_key[a] != penalty_key[b]) begin
            return penalty_key[a] < penalty_key[b];
        end
        if (energy_val[a] != energy_val[b]) begin
            return $signed(energy_val[a]) < $signed(energy_val[b]);
        end
        return a < b;
    endfunction

    // Store one score record; on round close, rank and build the victim pairs
    task automatic absorb_record(input t_item it);
        int                    cnt;
        int                    slot;
        int                    elite;
        int                    j;
        logic [IDX_W-1:0]      cur;
        logic [IDX_W-1:0]      order [MAX_REPLICAS];
        logic [COST_W:0]       sum;
        t_result               pr;
        cnt  = live_count(replica_cfg);
        slot = load_slot % MAX_REPLICAS;
        sum  = {1'b0, it.overlap_cost} + {1'b0, it.boundary_cost};
        round_pairs.delete();
        penalty_key[slot] = {~it.is_valid_solution, sum};
        energy_val[slot]  = it.total_energy;
        if (slot + 1 < cnt) begin
            load_slot = slot + 1;
            return;
        end
        load_slot = 0;
        for (int i = 0; i < cnt; i++) order[i] = IDX_W'(i);
        // insertion sort over the closed round
        for (int i = 1; i < cnt; i++) begin
            cur = order[i];
            j = i;
            while (j > 0 && ranks_first(int'(cur), int'(order[j-1]))) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        elite = (cnt + 3) / 4;
        for (int i = 0; i < cnt - elite; i++) begin
            pr.victim_index = order[elite + i];
            pr.source_index = order[i % elite];
            pr.final_pair   = (i == cnt - elite - 1);
            round_pairs.push_back(pr);
        end
    endtask

    function automatic t_item mk_rec(input bit v, input logic [31:0] ov,
                                     input logic [31:0] bd, input logic [31:0] en);
        t_item it;
        it.is_valid_solution = v;
        it.overlap_cost      = ov;
        it.boundary_cost     = bd;
        it.total_energy      = en;
        return it;
    endfunction

    function automatic t_result mk_pair(input int v, input int s, input bit f);
        t_result r;
        r.victim_index = IDX_W'(v);
        r.source_index = IDX_W'(s);
        r.final_pair   = f;
        return r;
    endfunction

    task automatic add_row(input t_row_kind k, input logic [CFG_W-1:0] c,
                           input t_item r, input t_result w);
        t_row row;
        row.kind = k;
        row.cfg  = c;
        row.rec  = r;
        row.want = w;
        plan.push_back(row);
    endtask

    function automatic logic [31:0] pick_cost();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return {16'($urandom_range(0, 255)), 16'h0};
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_energy();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return 32'($signed($urandom_range(0, 64)) - 32) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // Random score record; now and then a repeat of the previous one to force ties
    function automatic t_item random_record();
        t_item it;
        if ($urandom_range(0, 6) == 0) begin
            it = last_rec;
        end else begin
            it = mk_rec(1'($urandom_range(0, 1)), pick_cost(), pick_cost(), pick_energy());
        end
        last_rec = it;
        return it;
    endfunction

    // One score transaction; waits for the block to take it
    task automatic send_record(input t_item it, input bit typed, input t_result want);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        items_sent++;
        absorb_record(it);
        if (round_pairs.size() > 0) rounds_closed++;
        if (typed) begin
            pending_pairs.push_back(want);
        end else begin
            foreach (round_pairs[p]) pending_pairs.push_back(round_pairs[p]);
        end
    endtask

    task automatic random_gap(input bit burst);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!burst) begin
            if (r >= 90) gap = $urandom_range(8, 40);
            else if (r >= 55) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain all owed pairs, then let in-flight records finish
    task automatic settle();
        start <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        replica_cfg = v;
        cfg_writes++;
    endtask

    // Pair checker: the receiver cannot stall, so every strobe is one transaction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            pairs_seen++;
            if (pending_pairs.size() == 0) begin
                $error("unexpected pair: victim %0d source %0d final %0b",
                       o_result.victim_index, o_result.source_index, o_result.final_pair);
                errors++;
            end else begin
                want = pending_pairs.pop_front();
                if (o_result.victim_index !== want.victim_index) begin
                    $error("victim_index expected %0d got %0d",
                           want.victim_index, o_result.victim_index);
                    errors++;
                end
                if (o_result.source_index !== want.source_index) begin
                    $error("source_index expected %0d got %0d",
                           want.source_index, o_result.source_index);
                    errors++;
                end
                if (o_result.final_pair !== want.final_pair) begin
                    $error("final_pair expected %0b got %0b",
                           want.final_pair, o_result.final_pair);
                    errors++;
                end
            end
        end
    end

    // Watchdog: no transaction in either direction for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int               n;
        int               eff;
        bit               burst;
        logic [CFG_W-1:0] cv;

        foreach (penalty_key[s]) begin
            penalty_key[s] = '0;
            energy_val[s]  = '0;
        end

        // Directed rows: reset count of 8 with extremes and ties
        add_row(ROW_RECORD, 0, mk_rec(1, 0, 0, 0), '0);
        add_row(ROW_RECORD, 0, mk_rec(0, 0, 0, 32'h8000_0000), '0);
        add_row(ROW_RECORD, 0, mk_rec(1, '1, '1, 32'h7FFF_FFFF), '0);
        add_row(ROW_RECORD, 0, mk_rec(1, 0, 0, 32'h8000_0000), '0);
        add_row(ROW_RECORD, 0, mk_rec(1, 0, 0, 0), '0);
        add_row(ROW_RECORD, 0, mk_rec(0, '1, '1, 32'h7FFF_FFFF), '0);
        add_row(ROW_RECORD, 0, mk_rec(1, 32'h0001_0000, 0, 32'hFFFF_0000), '0);
        add_row(ROW_RECORD, 0, mk_rec(1, 0, 32'h0001_0000, 32'hFFFF_0000), '0);
        // Two replicas: one elite, one pair per round
        add_row(ROW_CFG, 2, '0, '0);
        // feasible beats infeasible even at saturated penalty
        add_row(ROW_RECORD, 0, mk_rec(1, '1, '1, 0), '0);
        add_row(ROW_TYPED, 0, mk_rec(0, 0, 0, 0), mk_pair(1, 0, 1));
        // signed energy: most negative wins
        add_row(ROW_RECORD, 0, mk_rec(1, 0, 0, 32'h7FFF_FFFF), '0);
        add_row(ROW_TYPED, 0, mk_rec(1, 0, 0, 32'h8000_0000), mk_pair(0, 1, 1));
        // full tie falls back to index
        add_row(ROW_RECORD, 0, mk_rec(0, 32'h0001_0000, 32'h8000, 32'h2_0000), '0);
        add_row(ROW_TYPED, 0, mk_rec(0, 32'h0001_0000, 32'h8000, 32'h2_0000), mk_pair(1, 0, 1));
        // penalty sum carries into bit 32 and outranks energy
        add_row(ROW_RECORD, 0, mk_rec(1, '1, 1, 32'h8000_0000), '0);
        add_row(ROW_TYPED, 0, mk_rec(1, 0, '1, 32'h7FFF_FFFF), mk_pair(0, 1, 1));
        // zero count behaves as one: round closes with no pairs
        add_row(ROW_CFG, 0, '0, '0);
        add_row(ROW_RECORD, 0, mk_rec(1, 32'h1234_5678, 0, 32'hDEAD_BEEF), '0);
        // count lowered in the middle of a round
        add_row(ROW_CFG, 5, '0, '0);
        add_row(ROW_RECORD, 0, mk_rec(0, 5, 5, 0), '0);
        add_row(ROW_RECORD, 0, mk_rec(1, 5, 5, 0), '0);
        add_row(ROW_RECORD, 0, mk_rec(1, 0, 0, 0), '0);
        add_row(ROW_CFG, 2, '0, '0);
        add_row(ROW_RECORD, 0, mk_rec(1, 0, 0, 0), '0);
        // single replica
        add_row(ROW_CFG, 1, '0, '0);
        add_row(ROW_RECORD, 0, mk_rec(0, '1, '1, 32'h8000_0000), '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                settle();
                write_count(plan[r].cfg);
            end else begin
                send_record(plan[r].rec, plan[r].kind == ROW_TYPED, plan[r].want);
                random_gap(1'b0);
            end
        end

        // Random phases: mostly whole rounds, some cut short before a count change
        while (items_sent < TARGET_ITEMS) begin
            settle();
            case ($urandom_range(0, 9))
                0:       cv = 0;
                1:       cv = 1;
                2:       cv = CFG_W'(MAX_REPLICAS);
                3:       cv = '1;
                4:       cv = 2;
                5:       cv = CFG_W'($urandom_range(MAX_REPLICAS + 1, 30));
                default: cv = CFG_W'($urandom_range(1, MAX_REPLICAS));
            endcase
            write_count(cv);
            eff = live_count(cv);
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, eff);
            end else begin
                n = ((load_slot + 1 >= eff) ? 1 : eff - load_slot)
                    + eff * $urandom_range(0, 2);
            end
            repeat (n) begin
                send_record(random_record(), 1'b0, '0);
                random_gap(burst);
            end
        end

        settle();

        $display("Ran %0d score records over %0d closed rounds with %0d count writes",
                 items_sent, rounds_closed, cfg_writes);
        $display("Checked %0d victim pairs, %0d errors", pairs_seen, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
